>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl modules
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/core/sft_pkg.sv
// shared types and constants for the symbol frequency table
// no dependencies
`default_nettype none

package sft_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int COUNT_BITS_DEF    = 16;
  localparam int SYM_BITS          = 8;
  localparam int FREQ_BITS         = 16;
  localparam int REG_IDX_BITS      = 1;
  localparam int CFG_DATA_BITS     = 8;

  localparam logic [SYM_BITS-1:0]  IGNORED_SYMBOL_RST = 8'd32;
  localparam logic [FREQ_BITS-1:0] FREQ_MAX           = 16'hFFFF;

  // register indexes
  localparam logic [REG_IDX_BITS-1:0] REG_IGNORED_SYMBOL = 1'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_IGNORE_ENABLE  = 1'd1;

  // token travelling up the cell chain
  typedef struct packed {
    logic                live;       // slot carries an item
    logic                countable;  // symbol still waiting for a home
    logic                last;       // end of the stream
    logic [SYM_BITS-1:0] sym;
  } sft_tok_t;

  typedef enum logic [2:0] {
    ST_RUN    = 3'b001,
    ST_DRAIN  = 3'b010,
    ST_REPORT = 3'b100
  } sft_state_t;

endpackage

`default_nettype wire

>>> rtl/core/sft_cell.sv
// one table cell: holds one entry, absorbs or forwards the passing token,
// shifts its entry down during the report; uses sft_pkg
`default_nettype none

module sft_cell #(
  parameter int COUNT_BITS = sft_pkg::COUNT_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire sft_pkg::sft_tok_t            tok_in,
  output sft_pkg::sft_tok_t                 tok_out,
  input  wire logic                         shift,
  input  wire logic                         above_valid,
  input  wire logic [sft_pkg::SYM_BITS-1:0] above_sym,
  input  wire logic [COUNT_BITS-1:0]        above_count,
  output logic                              ent_valid,
  output logic [sft_pkg::SYM_BITS-1:0]      ent_sym,
  output logic [COUNT_BITS-1:0]             ent_count
);

  logic                          valid_r, valid_nxt;
  logic [sft_pkg::SYM_BITS-1:0]  sym_r, sym_nxt;
  logic [COUNT_BITS-1:0]         count_r, count_nxt;
  sft_pkg::sft_tok_t             tok_r, tok_nxt;

  // absorb, claim or forward the token; shift entries during report
  always_comb begin
    valid_nxt = valid_r;
    sym_nxt   = sym_r;
    count_nxt = count_r;
    tok_nxt   = tok_in;
    if (shift) begin
      valid_nxt = above_valid;
      sym_nxt   = above_sym;
      count_nxt = above_count;
    end else if (tok_in.live && tok_in.countable) begin
      if (valid_r && (sym_r == tok_in.sym)) begin
        if (count_r != {COUNT_BITS{1'b1}}) begin
          count_nxt = count_r + COUNT_BITS'(1);
        end
        tok_nxt.countable = 1'b0;
      end else if (!valid_r) begin
        valid_nxt         = 1'b1;
        sym_nxt           = tok_in.sym;
        count_nxt         = COUNT_BITS'(1);
        tok_nxt.countable = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    sym_r   <= sym_nxt;
    count_r <= count_nxt;
  end

  assign tok_out   = tok_r;
  assign ent_valid = valid_r;
  assign ent_sym   = sym_r;
  assign ent_count = count_r;

endmodule

`default_nettype wire

>>> rtl/core/symbol_frequency_table_top.sv
// Flow: a byte moves one cell per cycle; after a last-marked item the input stalls while
// the chain drains to the top cell; the state and output registers then give the first
// report item; the report has max(entries, 1) items, one per cycle with out_tready high.
// Throughput: one byte per cycle while counting; none during the drain and the report,
// whose pace is set by the shift chain and out_tready.
// Reset: synchronous, active low; empties the table, clears overflow and the output
// valid, and sets the ignored symbol to a space with the filter on.
`default_nettype none
`include "assert_macros.svh"

module symbol_frequency_table_top #(
  parameter int TABLE_ENTRIES = sft_pkg::TABLE_ENTRIES_DEF,
  parameter int COUNT_BITS    = sft_pkg::COUNT_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [7:0]                        in_tdata,   // [7:0] symbol
  input  wire logic                              in_tlast,   // last
  // result channel
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [23:0]                            out_tdata,  // [7:0] out_symbol, [23:8] frequency
  output logic                                   out_tuser,  // [0] overflow
  output logic                                   out_tlast,  // final_res
  // configuration
  input  wire logic                              cfg_wr_en,
  input  wire logic [sft_pkg::REG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [sft_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  sft_pkg::sft_state_t           state_r, state_nxt;
  logic [sft_pkg::SYM_BITS-1:0]  ign_sym_r;
  logic                          ign_en_r;
  logic                          overflow_r, overflow_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [sft_pkg::SYM_BITS-1:0]  out_sym_r, out_sym_nxt;
  logic [sft_pkg::FREQ_BITS-1:0] out_freq_r, out_freq_nxt;
  logic                          out_ovf_r, out_fin_r, out_fin_nxt;

  sft_pkg::sft_tok_t             tok [0:TABLE_ENTRIES];
  logic                          ev  [0:TABLE_ENTRIES];
  logic [sft_pkg::SYM_BITS-1:0]  es  [0:TABLE_ENTRIES];
  logic [COUNT_BITS-1:0]         ec  [0:TABLE_ENTRIES];

  logic                          load;
  logic                          shift;
  logic [31:0]                   count_ext;

  // input token into the chain
  assign in_tready = (state_r == sft_pkg::ST_RUN);

  always_comb begin
    tok[0].live      = in_tvalid && in_tready;
    tok[0].countable = !(ign_en_r && (in_tdata == ign_sym_r));
    tok[0].last      = in_tlast;
    tok[0].sym       = in_tdata;
  end

  // empty slot above the top cell
  assign ev[TABLE_ENTRIES] = 1'b0;
  assign es[TABLE_ENTRIES] = '0;
  assign ec[TABLE_ENTRIES] = '0;

  // the cell chain
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    sft_cell #(
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .tok_in      (tok[i]),
      .tok_out     (tok[i+1]),
      .shift       (shift),
      .above_valid (ev[i+1]),
      .above_sym   (es[i+1]),
      .above_count (ec[i+1]),
      .ent_valid   (ev[i]),
      .ent_sym     (es[i]),
      .ent_count   (ec[i])
    );
  end

  // report control
  assign load      = (state_r == sft_pkg::ST_REPORT) && (!out_valid_r || out_tready);
  assign shift     = load && ev[0];
  assign count_ext = 32'(ec[0]);

  always_comb begin
    out_sym_nxt  = '0;
    out_freq_nxt = '0;
    out_fin_nxt  = 1'b1;
    if (ev[0]) begin
      out_sym_nxt  = es[0];
      out_freq_nxt = (count_ext > 32'(sft_pkg::FREQ_MAX)) ? sft_pkg::FREQ_MAX
                                                          : count_ext[15:0];
      out_fin_nxt  = !ev[1];
    end
  end

  // run, drain after a last-marked item, then report
  always_comb begin
    state_nxt    = state_r;
    overflow_nxt = overflow_r;
    unique case (state_r)
      sft_pkg::ST_RUN: begin
        if (tok[TABLE_ENTRIES].live && tok[TABLE_ENTRIES].countable) begin
          overflow_nxt = 1'b1;
        end
        if (in_tvalid && in_tlast) begin
          state_nxt = sft_pkg::ST_DRAIN;
        end
      end
      sft_pkg::ST_DRAIN: begin
        if (tok[TABLE_ENTRIES].live && tok[TABLE_ENTRIES].countable) begin
          overflow_nxt = 1'b1;
        end
        if (tok[TABLE_ENTRIES].live && tok[TABLE_ENTRIES].last) begin
          state_nxt = sft_pkg::ST_REPORT;
        end
      end
      sft_pkg::ST_REPORT: begin
        if (load && out_fin_nxt) begin
          state_nxt    = sft_pkg::ST_RUN;
          overflow_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = sft_pkg::ST_RUN;
      end
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sft_pkg::ST_RUN;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ign_sym_r   <= sft_pkg::IGNORED_SYMBOL_RST;
      ign_en_r    <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          sft_pkg::REG_IGNORED_SYMBOL: ign_sym_r <= cfg_wdata[7:0];
          sft_pkg::REG_IGNORE_ENABLE:  ign_en_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_sym_r  <= out_sym_nxt;
      out_freq_r <= out_freq_nxt;
      out_ovf_r  <= overflow_r;
      out_fin_r  <= out_fin_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_freq_r, out_sym_r};
  assign out_tuser  = out_ovf_r;
  assign out_tlast  = out_fin_r;

  // checks
  `ASSERT_SAME(a_state_onehot, clk, rst_n, 1'b1, $onehot(state_r))
  `ASSERT_NEXT(a_drain_to_report, clk, rst_n,
               (state_r == sft_pkg::ST_DRAIN) && tok[TABLE_ENTRIES].live
               && tok[TABLE_ENTRIES].last,
               state_r == sft_pkg::ST_REPORT)
  `ASSERT_NEXT(a_final_clears, clk, rst_n, load && out_fin_nxt,
               (state_r == sft_pkg::ST_RUN) && !overflow_r && !ev[0])
  `ASSERT_SAME(a_no_token_in_report, clk, rst_n, state_r == sft_pkg::ST_REPORT,
               !tok[TABLE_ENTRIES].live && !in_tready)

endmodule

`default_nettype wire
